// ===== rtl/core/kpvt_pkg.sv =====
package kpvt_pkg;

	localparam int OP_W = 4;

	localparam logic [OP_W-1:0] OP_TV     = 4'd0;
	localparam logic [OP_W-1:0] OP_HA     = 4'd1;
	localparam logic [OP_W-1:0] OP_TA     = 4'd2;
	localparam logic [OP_W-1:0] OP_P10T   = 4'd3;
	localparam logic [OP_W-1:0] OP_P11T   = 4'd4;
	localparam logic [OP_W-1:0] OP_K0I    = 4'd5;
	localparam logic [OP_W-1:0] OP_K1I    = 4'd6;
	localparam logic [OP_W-1:0] OP_P01T   = 4'd7;
	localparam logic [OP_W-1:0] OP_AP01T  = 4'd8;
	localparam logic [OP_W-1:0] OP_K0C    = 4'd9;
	localparam logic [OP_W-1:0] OP_K0P01  = 4'd10;
	localparam logic [OP_W-1:0] OP_K1C    = 4'd11;
	localparam logic [OP_W-1:0] OP_K1P01  = 4'd12;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_SQ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_PP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_PV = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VV = 3'd5;

	localparam int CFG_DATA_W = 63;

	localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd6554;
	localparam logic [31:0] RST_HALF_PERIOD_SQ = 32'd328;
	localparam logic [62:0] RST_MEAS_VAR = 63'd10214797273574;
	localparam logic [62:0] RST_NOISE_PP = 63'd102148;
	localparam logic [62:0] RST_NOISE_PV = 63'd2042960;
	localparam logic [62:0] RST_NOISE_VV = 63'd40859183;

	typedef struct packed {
		logic            load;
		logic            mul_start;
		logic            mul_wb;
		logic            div_start;
		logic            div_wb;
		logic            commit;
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} sts_t;

endpackage

// ===== rtl/core/kpvt_mul.sv =====
module kpvt_mul #(
	parameter int DATA_FRAC_BITS = 16,
	parameter int COV_FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cov_shift,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] res
);

	localparam logic [2:0] STEP_ROUND = 3'd4;
	localparam logic [2:0] STEP_SAT = 3'd5;
	localparam logic [127:0] RND_D = 128'(1) << (DATA_FRAC_BITS - 1);
	localparam logic [127:0] RND_C = 128'(1) << (COV_FRAC_BITS - 1);

	logic [63:0]  mx_q, my_q;
	logic         neg_q, cov_q, busy_q, done_q;
	logic [2:0]   cnt_q;
	logic [127:0] acc_q;
	logic [63:0]  res_q;
	logic [31:0]  xa, yb;
	logic [63:0]  pp;
	logic [127:0] pp_sh, rsum, rshift;
	logic [63:0]  sat_v;

	always_comb begin
		xa = cnt_q[0] ? mx_q[63:32] : mx_q[31:0];
		yb = cnt_q[1] ? my_q[63:32] : my_q[31:0];
		pp = 64'(xa) * 64'(yb);
		case ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})
			2'd0: pp_sh = {64'b0, pp};
			2'd1: pp_sh = {32'b0, pp, 32'b0};
			default: pp_sh = {pp, 64'b0};
		endcase
		rsum = acc_q + (cov_q ? RND_C : RND_D);
		rshift = cov_q ? (rsum >> COV_FRAC_BITS) : (rsum >> DATA_FRAC_BITS);
		if (neg_q) begin
			sat_v = (acc_q[127:63] != '0) ? 64'h8000_0000_0000_0000 : (64'd0 - acc_q[63:0]);
		end else begin
			sat_v = (acc_q[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : acc_q[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == STEP_SAT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mx_q <= a[63] ? 64'd0 - 64'(a) : 64'(a);
			my_q <= b[63] ? 64'd0 - 64'(b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			cov_q <= cov_shift;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < STEP_ROUND) begin
				acc_q <= acc_q + pp_sh;
			end else if (cnt_q == STEP_ROUND) begin
				acc_q <= rshift;
			end else begin
				res_q <= sat_v;
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== rtl/core/kpvt_div.sv =====
module kpvt_div #(
	parameter int COV_FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output logic               done,
	output logic signed [63:0] res
);

	localparam int NB = 64 + COV_FRAC_BITS;
	localparam int CW = $clog2(NB + 1);

	logic          busy_q, neg_q, ovf_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   n_q, rem_q, q_q, d_q;
	logic [64:0]   remsh, diff;
	logic          qbit;

	always_comb begin
		remsh = {rem_q, n_q[63]};
		diff = remsh - {1'b0, d_q};
		qbit = !diff[64];
		if (neg_q) begin
			res = (ovf_q || q_q[63]) ? 64'sh8000_0000_0000_0000 : $signed(64'd0 - q_q);
		end else begin
			res = (ovf_q || q_q[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(q_q);
		end
	end

	assign done = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NB);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num[63] ? 64'd0 - 64'(num) : 64'(num);
			d_q <= 64'(den);
			neg_q <= num[63];
			rem_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q && (cnt_q != '0)) begin
			n_q <= {n_q[62:0], 1'b0};
			rem_q <= qbit ? diff[63:0] : remsh[63:0];
			q_q <= {q_q[62:0], qbit};
			ovf_q <= ovf_q | q_q[63];
		end
	end

endmodule

// ===== rtl/core/kpvt_ctrl.sv =====
module kpvt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic           m_tready,
	output logic           m_tvalid,
	input  kpvt_pkg::sts_t sts,
	output kpvt_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_MWAIT = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_DWAIT = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0]                    state_q;
	logic [kpvt_pkg::OP_W-1:0]     op_q;
	logic                          mval_q;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		case (state_q)
			S_IDLE: cmd.load = s_tvalid;
			S_MUL: cmd.mul_start = 1'b1;
			S_MWAIT: cmd.mul_wb = sts.mul_done;
			S_DIV: cmd.div_start = 1'b1;
			S_DWAIT: cmd.div_wb = sts.div_done;
			S_OUT: cmd.commit = !mval_q || m_tready;
			default: cmd = '0;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= kpvt_pkg::OP_TV;
			mval_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				mval_q <= 1'b1;
			end else if (m_tready) begin
				mval_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q <= kpvt_pkg::OP_TV;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sts.mul_done) begin
						if (op_q == kpvt_pkg::OP_P11T) begin
							state_q <= S_DIV;
						end else if (op_q == kpvt_pkg::OP_K1P01) begin
							state_q <= S_OUT;
						end else begin
							op_q <= op_q + kpvt_pkg::OP_W'(1);
							state_q <= S_MUL;
						end
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (sts.div_done) begin
						op_q <= kpvt_pkg::OP_K0I;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/kpvt_dp.sv =====
module kpvt_dp #(
	parameter int DATA_FRAC_BITS = 16,
	parameter int COV_FRAC_BITS = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kpvt_pkg::cmd_t                      cmd,
	output kpvt_pkg::sts_t                      sts,
	input  logic                                cfg_we,
	input  logic [kpvt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kpvt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [63:0]                         in_data,
	output logic [63:0]                         out_data
);

	function automatic logic signed [63:0] sat_add(logic signed [63:0] x, logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63]) begin
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(logic signed [63:0] x, logic signed [63:0] y);
		logic signed [64:0] s;
		s = {x[63], x} - {y[63], y};
		if (s[64] != s[63]) begin
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v[63:31] != {33{v[63]}}) begin
			return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[31:0];
	endfunction

	logic [31:0]        t_q, h_q;
	logic [62:0]        r_q, qpp_q, qpv_q, qvv_q;
	logic signed [31:0] x_q, v_q, acc_q, z_q, pp_q, vp_q, out_pos_q, out_vel_q;
	logic signed [32:0] inn_q;
	logic signed [63:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [63:0] ppw_q, ap00_q, ap01_q, n10_q, k0_q, k1_q, cpa0_q, n00_q;
	logic signed [63:0] np00_q, np01_q, np10_q, np11_q;

	logic signed [63:0] ma, mb, mres, s_val, q0, q1, tsx;
	logic               mcov, mdone, d0done, d1done, s_pos;
	logic signed [31:0] pp_new;

	assign tsx = $signed({32'b0, t_q});
	assign s_val = sat_add(p00_q, $signed({1'b0, r_q}));
	assign s_pos = !s_val[63] && (s_val != '0);
	assign pp_new = sat32(sat_add(ppw_q, mres));

	always_comb begin
		ma = tsx;
		mb = 64'(v_q);
		mcov = 1'b0;
		case (cmd.op)
			kpvt_pkg::OP_TV: begin
				ma = tsx; mb = 64'(v_q);
			end
			kpvt_pkg::OP_HA: begin
				ma = $signed({32'b0, h_q}); mb = 64'(acc_q);
			end
			kpvt_pkg::OP_TA: begin
				ma = tsx; mb = 64'(acc_q);
			end
			kpvt_pkg::OP_P10T: begin
				ma = p10_q; mb = tsx;
			end
			kpvt_pkg::OP_P11T: begin
				ma = p11_q; mb = tsx;
			end
			kpvt_pkg::OP_K0I: begin
				ma = k0_q; mb = 64'(inn_q); mcov = 1'b1;
			end
			kpvt_pkg::OP_K1I: begin
				ma = k1_q; mb = 64'(inn_q); mcov = 1'b1;
			end
			kpvt_pkg::OP_P01T: begin
				ma = p01_q; mb = tsx;
			end
			kpvt_pkg::OP_AP01T: begin
				ma = ap01_q; mb = tsx;
			end
			kpvt_pkg::OP_K0C: begin
				ma = k0_q; mb = cpa0_q; mcov = 1'b1;
			end
			kpvt_pkg::OP_K0P01: begin
				ma = k0_q; mb = p01_q; mcov = 1'b1;
			end
			kpvt_pkg::OP_K1C: begin
				ma = k1_q; mb = cpa0_q; mcov = 1'b1;
			end
			kpvt_pkg::OP_K1P01: begin
				ma = k1_q; mb = p01_q; mcov = 1'b1;
			end
			default: begin
				ma = tsx; mb = 64'(v_q);
			end
		endcase
	end

	kpvt_mul #(
		.DATA_FRAC_BITS(DATA_FRAC_BITS),
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start), .cov_shift(mcov),
		.a(ma), .b(mb), .done(mdone), .res(mres)
	);

	kpvt_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div0 (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(ap00_q), .den(s_val), .done(d0done), .res(q0)
	);

	kpvt_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div1 (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(p10_q), .den(s_val), .done(d1done), .res(q1)
	);

	assign sts.mul_done = mdone;
	assign sts.div_done = d0done && d1done;
	assign out_data = {out_vel_q, out_pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= kpvt_pkg::RST_SAMPLE_PERIOD;
			h_q <= kpvt_pkg::RST_HALF_PERIOD_SQ;
			r_q <= kpvt_pkg::RST_MEAS_VAR;
			qpp_q <= kpvt_pkg::RST_NOISE_PP;
			qpv_q <= kpvt_pkg::RST_NOISE_PV;
			qvv_q <= kpvt_pkg::RST_NOISE_VV;
			x_q <= '0;
			v_q <= '0;
			p00_q <= $signed({1'b0, kpvt_pkg::RST_NOISE_PP});
			p01_q <= $signed({1'b0, kpvt_pkg::RST_NOISE_PV});
			p10_q <= $signed({1'b0, kpvt_pkg::RST_NOISE_PV});
			p11_q <= $signed({1'b0, kpvt_pkg::RST_NOISE_VV});
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kpvt_pkg::CFG_SAMPLE_PERIOD: t_q <= cfg_data[31:0];
					kpvt_pkg::CFG_HALF_PERIOD_SQ: h_q <= cfg_data[31:0];
					kpvt_pkg::CFG_MEAS_VAR: r_q <= cfg_data;
					kpvt_pkg::CFG_NOISE_PP: qpp_q <= cfg_data;
					kpvt_pkg::CFG_NOISE_PV: qpv_q <= cfg_data;
					kpvt_pkg::CFG_NOISE_VV: qvv_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.mul_wb && cmd.op == kpvt_pkg::OP_K0I) begin
				x_q <= sat32(sat_add(64'(pp_q), mres));
			end
			if (cmd.mul_wb && cmd.op == kpvt_pkg::OP_K1I) begin
				v_q <= sat32(sat_add(64'(vp_q), mres));
			end
			if (cmd.commit) begin
				p00_q <= np00_q;
				p01_q <= np01_q;
				p10_q <= np10_q;
				p11_q <= np11_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= $signed(in_data[31:0]);
			z_q <= $signed(in_data[63:32]);
		end
		if (cmd.div_wb) begin
			k0_q <= s_pos ? q0 : '0;
			k1_q <= s_pos ? q1 : '0;
		end
		if (cmd.commit) begin
			out_pos_q <= x_q;
			out_vel_q <= v_q;
		end
		if (cmd.mul_wb) begin
			case (cmd.op)
				kpvt_pkg::OP_TV: ppw_q <= sat_add(64'(x_q), mres);
				kpvt_pkg::OP_HA: begin
					pp_q <= pp_new;
					inn_q <= 33'(z_q) - 33'(pp_new);
				end
				kpvt_pkg::OP_TA: vp_q <= sat32(sat_add(64'(v_q), mres));
				kpvt_pkg::OP_P10T: ap00_q <= sat_add(p00_q, mres);
				kpvt_pkg::OP_P11T: begin
					ap01_q <= sat_add(p01_q, mres);
					n10_q <= sat_add(p10_q, mres);
				end
				kpvt_pkg::OP_P01T: cpa0_q <= sat_add(p00_q, mres);
				kpvt_pkg::OP_AP01T: n00_q <= sat_add(ap00_q, mres);
				kpvt_pkg::OP_K0C:
					np00_q <= sat_add(sat_sub(n00_q, mres), $signed({1'b0, qpp_q}));
				kpvt_pkg::OP_K0P01:
					np01_q <= sat_add(sat_sub(ap01_q, mres), $signed({1'b0, qpv_q}));
				kpvt_pkg::OP_K1C:
					np10_q <= sat_add(sat_sub(n10_q, mres), $signed({1'b0, qpv_q}));
				kpvt_pkg::OP_K1P01:
					np11_q <= sat_add(sat_sub(p11_q, mres), $signed({1'b0, qvv_q}));
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/kalman_position_velocity_tracker.sv =====
// Two-state position/velocity Kalman tracker, one filter step per item.
// Input channel s_axis_*: each item carries an acceleration and a position
// measurement (Q16.16). Output channel m_axis_*: one item per input with the
// corrected position and velocity estimates (Q16.16, saturating).
// Configuration: cfg_we/cfg_index/cfg_data write period, T^2/2, measurement
// variance and process noise terms; write only while no item is in flight.
// One shared multiplier builds each 64x64 product from four 32x32 partial
// products (13 products), and two bit-serial dividers run side by side to
// form both gains. One item is processed at a time; s_axis_tready is high
// only while the block waits for the next item.
// The result sits in an output register; the next item is accepted while it
// waits. If m_axis_tready stays low the finished step holds before its commit
// until the register drains.
// Reset clears the estimates to zero, loads the registers with their defaults
// and the covariance with the default process noise terms.
module kalman_position_velocity_tracker #(
	parameter int DATA_FRAC_BITS = 16,
	parameter int COV_FRAC_BITS = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [63:0]                     s_axis_tdata,  // acceleration, position_measurement
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [63:0]                     m_axis_tdata,  // position_estimate, velocity_estimate
	input  logic                            cfg_we,
	input  logic [kpvt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kpvt_pkg::CFG_DATA_W-1:0] cfg_data
);

	kpvt_pkg::cmd_t cmd;
	kpvt_pkg::sts_t sts;

	kpvt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.m_tready(m_axis_tready), .m_tvalid(m_axis_tvalid),
		.sts(sts), .cmd(cmd)
	);

	kpvt_dp #(
		.DATA_FRAC_BITS(DATA_FRAC_BITS),
		.COV_FRAC_BITS(COV_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_data(s_axis_tdata), .out_data(m_axis_tdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a step was running");

	a_done_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.mul_done && sts.div_done))
		else $error("multiplier and divider finished together");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result committed over a pending output item");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_axis_tvalid)
		else $error("committed result not presented");

endmodule

// ===== tb/tb_kalman_position_velocity_tracker.sv =====
module tb_kalman_position_velocity_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [kpvt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [kpvt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int DFB = 16;
	localparam int CFB = 40;
	localparam longint LMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint LMIN = 64'sh8000_0000_0000_0000;
	localparam int SETTLE_CYCLES = 400;

	class kalman_tracker_scoreboard;
		longint period, half_sq, meas_var, q_pp, q_pv, q_vv;
		longint pos, vel, c_pp, c_pv, c_vp, c_vv;
		logic [63:0] estimates_q[$];
		int errors;
		int results;

		function new();
			period = kpvt_pkg::RST_SAMPLE_PERIOD;
			half_sq = kpvt_pkg::RST_HALF_PERIOD_SQ;
			meas_var = kpvt_pkg::RST_MEAS_VAR;
			q_pp = kpvt_pkg::RST_NOISE_PP;
			q_pv = kpvt_pkg::RST_NOISE_PV;
			q_vv = kpvt_pkg::RST_NOISE_VV;
			pos = 0;
			vel = 0;
			c_pp = q_pp;
			c_pv = q_pv;
			c_vp = q_pv;
			c_vv = q_vv;
			errors = 0;
			results = 0;
		endfunction

		function void write_reg(logic [kpvt_pkg::CFG_IDX_W-1:0] idx,
				logic [kpvt_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				kpvt_pkg::CFG_SAMPLE_PERIOD: period = {32'd0, data[31:0]};
				kpvt_pkg::CFG_HALF_PERIOD_SQ: half_sq = {32'd0, data[31:0]};
				kpvt_pkg::CFG_MEAS_VAR: meas_var = {1'b0, data};
				kpvt_pkg::CFG_NOISE_PP: q_pp = {1'b0, data};
				kpvt_pkg::CFG_NOISE_PV: q_pv = {1'b0, data};
				kpvt_pkg::CFG_NOISE_VV: q_vv = {1'b0, data};
				default: ;
			endcase
		endfunction

		function longint sat_mag(logic [127:0] m, bit neg);
			if (neg) begin
				if (m >= 128'h8000_0000_0000_0000)
					return LMIN;
				return -longint'(m[63:0]);
			end
			if (m > 128'h7FFF_FFFF_FFFF_FFFF)
				return LMAX;
			return longint'(m[63:0]);
		endfunction

		function logic [63:0] mag(longint v);
			logic [63:0] u;
			u = v;
			return (v < 0) ? -u : u;
		endfunction

		function longint mul_round(longint a, longint b, int sh);
			logic [127:0] m;
			m = {64'd0, mag(a)} * {64'd0, mag(b)};
			if (sh > 0)
				m = (m + (128'd1 << (sh - 1))) >> sh;
			return sat_mag(m, (a < 0) != (b < 0));
		endfunction

		function longint div_frac(longint num, longint den, int sh);
			logic [127:0] src;
			logic [127:0] q;
			src = {64'd0, mag(num)} << sh;
			q = src / {64'd0, 64'(den)};
			return sat_mag(q, num < 0);
		endfunction

		function longint add_sat(longint a, longint b);
			logic [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63])
				return s[64] ? LMIN : LMAX;
			return longint'(s[63:0]);
		endfunction

		function longint sub_sat(longint a, longint b);
			logic [64:0] s;
			s = {a[63], a} - {b[63], b};
			if (s[64] != s[63])
				return s[64] ? LMIN : LMAX;
			return longint'(s[63:0]);
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function void note_input(logic [31:0] acc_bits, logic [31:0] meas_bits);
			longint acc, z, pp, vp, inn, s, k0, k1, ap00, ap01, cpa0, n;
			longint p00, p01, p10, p11;
			logic [31:0] pos_bits, vel_bits;
			acc = longint'(signed'(acc_bits));
			z = longint'(signed'(meas_bits));
			p00 = c_pp;
			p01 = c_pv;
			p10 = c_vp;
			p11 = c_vv;
			k0 = 0;
			k1 = 0;
			pp = add_sat(pos, mul_round(period, vel, DFB));
			pp = clip32(add_sat(pp, mul_round(half_sq, acc, DFB)));
			vp = clip32(add_sat(vel, mul_round(period, acc, DFB)));
			inn = z - pp;
			ap00 = add_sat(p00, mul_round(p10, period, DFB));
			ap01 = add_sat(p01, mul_round(p11, period, DFB));
			s = add_sat(p00, meas_var);
			if (s > 0) begin
				k0 = div_frac(ap00, s, CFB);
				k1 = div_frac(p10, s, CFB);
			end
			pos = clip32(add_sat(pp, mul_round(k0, inn, CFB)));
			vel = clip32(add_sat(vp, mul_round(k1, inn, CFB)));
			cpa0 = add_sat(p00, mul_round(p01, period, DFB));
			n = add_sat(ap00, mul_round(ap01, period, DFB));
			n = sub_sat(n, mul_round(k0, cpa0, CFB));
			c_pp = add_sat(n, q_pp);
			n = sub_sat(ap01, mul_round(k0, p01, CFB));
			c_pv = add_sat(n, q_pv);
			n = add_sat(p10, mul_round(p11, period, DFB));
			n = sub_sat(n, mul_round(k1, cpa0, CFB));
			c_vp = add_sat(n, q_pv);
			n = sub_sat(p11, mul_round(k1, p01, CFB));
			c_vv = add_sat(n, q_vv);
			pos_bits = pos[31:0];
			vel_bits = vel[31:0];
			estimates_q.push_back({vel_bits, pos_bits});
		endfunction

		function void check_result(logic [63:0] data);
			logic [63:0] want;
			results++;
			if (estimates_q.size() == 0) begin
				errors++;
				$error("unexpected item %h", data);
				return;
			end
			want = estimates_q.pop_front();
			if (data[31:0] !== want[31:0]) begin
				errors++;
				$error("position_estimate expected %0d got %0d",
					$signed(want[31:0]), $signed(data[31:0]));
			end
			if (data[63:32] !== want[63:32]) begin
				errors++;
				$error("velocity_estimate expected %0d got %0d",
					$signed(want[63:32]), $signed(data[63:32]));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic cfg_we;
	logic [kpvt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kpvt_pkg::CFG_DATA_W-1:0] cfg_data;

	kalman_tracker_scoreboard sb;
	int src_idle_pct;
	int snk_idle_pct;
	int items_sent;
	int phases;

	kalman_position_velocity_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_kalman_position_velocity_tracker: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic send_item(logic [31:0] acc, logic [31:0] meas);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {meas, acc};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(acc, meas);
		items_sent++;
	endtask

	task automatic write_reg(logic [kpvt_pkg::CFG_IDX_W-1:0] idx,
			logic [kpvt_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.estimates_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(logic [kpvt_pkg::CFG_DATA_W-1:0] t,
			logic [kpvt_pkg::CFG_DATA_W-1:0] h,
			logic [kpvt_pkg::CFG_DATA_W-1:0] r, logic [kpvt_pkg::CFG_DATA_W-1:0] qpp,
			logic [kpvt_pkg::CFG_DATA_W-1:0] qpv, logic [kpvt_pkg::CFG_DATA_W-1:0] qvv);
		write_reg(kpvt_pkg::CFG_SAMPLE_PERIOD, t);
		write_reg(kpvt_pkg::CFG_HALF_PERIOD_SQ, h);
		write_reg(kpvt_pkg::CFG_MEAS_VAR, r);
		write_reg(kpvt_pkg::CFG_NOISE_PP, qpp);
		write_reg(kpvt_pkg::CFG_NOISE_PV, qpv);
		write_reg(kpvt_pkg::CFG_NOISE_VV, qvv);
		@(posedge clk);
		phases++;
	endtask

	function automatic logic [kpvt_pkg::CFG_DATA_W-1:0] rand_wide();
		return kpvt_pkg::CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(63));
	endfunction

	task automatic random_config();
		logic [kpvt_pkg::CFG_DATA_W-1:0] t, h;
		if ($urandom_range(3) == 0) begin
			load_config(rand_wide(), rand_wide(), rand_wide(), rand_wide(),
				rand_wide(), rand_wide());
		end else begin
			t = kpvt_pkg::CFG_DATA_W'($urandom_range(65536));
			h = (t * t) >> 17;
			load_config(t, h,
				kpvt_pkg::CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(20, 40)),
				kpvt_pkg::CFG_DATA_W'($urandom >> $urandom_range(31)),
				kpvt_pkg::CFG_DATA_W'($urandom >> $urandom_range(31)),
				kpvt_pkg::CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(24, 50)));
		end
	endtask

	task automatic random_item();
		logic [31:0] acc, meas, noise;
		case ($urandom_range(9))
			0: begin
				acc = $urandom;
				meas = $urandom;
			end
			1: begin
				acc = $urandom;
				meas = sb.pos[31:0];
			end
			default: begin
				acc = $urandom_range(2097152) - 1048576;
				noise = $urandom_range(1 << $urandom_range(4, 24));
				meas = sb.pos[31:0] + sb.vel[31:0] / 10 + noise - (noise >> 1);
			end
		endcase
		send_item(acc, meas);
	endtask

	initial begin
		int n;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_idle_pct = 38;
		snk_idle_pct = 70;
		items_sent = 0;
		phases = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults from reset, field extremes
		send_item(32'h0000_0000, 32'h0000_0000);
		send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 32'h8000_0000);
		send_item(32'h7FFF_FFFF, 32'h8000_0000);
		send_item(32'h8000_0000, 32'h7FFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'h0000_0001);
		send_item(32'h0001_0000, 32'h0010_0000);
		send_item(32'hAAAA_AAAA, 32'h5555_5555);
		drain();

		// zero period, zero R and Q_pp collapse P_pp so the innovation variance hits zero
		load_config(0, 0, 0, 0, 0, 0);
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, 63'h1234_5678);
		repeat (5) send_item($urandom, $urandom);
		drain();

		// everything at its top value
		load_config(63'hFFFF_FFFF, 63'hFFFF_FFFF, '1, '1, '1, '1);
		send_item(32'h7FFF_FFFF, 32'h8000_0000);
		send_item(32'h8000_0000, 32'h7FFF_FFFF);
		repeat (3) send_item($urandom, $urandom);
		drain();

		// noise written mid-run is used from then on, covariance kept
		write_reg(kpvt_pkg::CFG_NOISE_PP, kpvt_pkg::RST_NOISE_PP);
		write_reg(kpvt_pkg::CFG_NOISE_PV, kpvt_pkg::RST_NOISE_PV);
		write_reg(kpvt_pkg::CFG_NOISE_VV, kpvt_pkg::RST_NOISE_VV);
		load_config(63'(kpvt_pkg::RST_SAMPLE_PERIOD), 63'(kpvt_pkg::RST_HALF_PERIOD_SQ),
			kpvt_pkg::RST_MEAS_VAR, kpvt_pkg::RST_NOISE_PP,
			kpvt_pkg::RST_NOISE_PV, kpvt_pkg::RST_NOISE_VV);
		repeat (4) send_item($urandom_range(200000) - 100000, $urandom_range(4000000));
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin
				src_idle_pct = 70;
				snk_idle_pct = 38;
			end else if (p == 8) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			random_config();
			n = 100 + $urandom_range(20);
			repeat (n) random_item();
			drain();
		end

		$display("%0d items over %0d register settings, %0d results checked",
			items_sent, phases, sb.results);
		if (sb.errors == 0 && sb.estimates_q.size() == 0)
			$display("tb_kalman_position_velocity_tracker: clean");
		else
			$display("tb_kalman_position_velocity_tracker: errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/kpvt_pkg.sv
rtl/core/kpvt_mul.sv
rtl/core/kpvt_div.sv
rtl/core/kpvt_ctrl.sv
rtl/core/kpvt_dp.sv
rtl/core/kalman_position_velocity_tracker.sv
tb/tb_kalman_position_velocity_tracker.sv
